// File: rtl/core/fsr_pkg.sv
// Shared constants, types and tables of the Fourier shift phase ramp.
package fsr_pkg;

    localparam int MAX_LOG2_SIZE = 10;
    localparam int SAMPLE_BITS   = 16;
    localparam int PHASE_BITS    = 16;

    localparam int SHIFT_BITS   = 24;
    localparam int SHIFT_FRAC   = 12;
    localparam int SUM_FRAC     = SHIFT_FRAC + MAX_LOG2_SIZE;
    localparam int POS_BITS     = MAX_LOG2_SIZE;
    localparam int FREQ_BITS    = MAX_LOG2_SIZE + 1;
    localparam int LOG2_BITS    = 4;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = SHIFT_BITS;

    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CS_BITS      = 32;
    localparam int PROD_BITS    = SAMPLE_BITS + CS_BITS;
    localparam int SUM_BITS     = PROD_BITS + 2;
    localparam int ROUND_SHIFT  = 30;
    localparam int RES_BITS     = SUM_BITS - ROUND_SHIFT;

    localparam logic signed [CS_BITS-1:0] INV_GAIN = 32'sd652032874;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHIFT_X       = 3'd0,
        CFG_SHIFT_Y       = 3'd1,
        CFG_LOG2_WIDTH    = 3'd2,
        CFG_LOG2_HEIGHT   = 3'd3,
        CFG_PEAK_CENTERED = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SHIFT_BITS-1:0] shift_x;
        logic signed [SHIFT_BITS-1:0] shift_y;
        logic [LOG2_BITS-1:0]         log2_width;
        logic [LOG2_BITS-1:0]         log2_height;
        logic                         peak_centered;
    } t_cfg;

    // Angle stage: reduced CORDIC angle plus the sample
    typedef struct packed {
        logic                          valid;
        logic                          flip;
        logic signed [ANGLE_BITS-1:0]  z;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_ang;

    // CORDIC stage state
    typedef struct packed {
        logic                          valid;
        logic                          flip;
        logic signed [CS_BITS-1:0]     x;
        logic signed [CS_BITS-1:0]     y;
        logic signed [ANGLE_BITS-1:0]  z;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_cor;

    // Rotated sample leaving the pipeline
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } t_res;

    // Arctangent of 2^-step in units of 2^-32 turn
    function automatic logic signed [ANGLE_BITS-1:0] atan_turns(input int step);
        logic signed [ANGLE_BITS-1:0] v;
        case (step)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/fsr_if.sv
// Stream interfaces for spectrum samples in and rotated samples out.
interface fsr_in_if;
    import fsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [POS_BITS-1:0]           col;
    logic [POS_BITS-1:0]           row;
    logic signed [SAMPLE_BITS-1:0] in_re;
    logic signed [SAMPLE_BITS-1:0] in_im;

    modport source (output valid, output col, output row, output in_re, output in_im,
                    input ready);
    modport sink (input valid, input col, input row, input in_re, input in_im,
                  output ready);
endinterface

interface fsr_out_if;
    import fsr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;

    modport source (output valid, output out_re, output out_im, input ready);
    modport sink (input valid, input out_re, input out_im, output ready);
endinterface

// File: rtl/core/fsr_phase.sv
// Frequency index and phase ramp stages: position to reduced CORDIC angle.
module fsr_phase (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  fsr_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    input  logic [fsr_pkg::POS_BITS-1:0]          i_col,
    input  logic [fsr_pkg::POS_BITS-1:0]          i_row,
    input  logic signed [fsr_pkg::SAMPLE_BITS-1:0] i_re,
    input  logic signed [fsr_pkg::SAMPLE_BITS-1:0] i_im,
    output fsr_pkg::t_ang                         o_ang
);
    import fsr_pkg::*;

    localparam int RND_SHIFT = SUM_FRAC - PHASE_BITS;
    localparam int PROD_W    = SHIFT_BITS + FREQ_BITS;

    // Clamp a size exponent into the supported range
    function automatic logic [LOG2_BITS-1:0] clamp_log2(input logic [LOG2_BITS-1:0] v);
        logic [LOG2_BITS-1:0] r;
        if (v == '0) begin
            r = LOG2_BITS'(1);
        end else if (v > LOG2_BITS'(MAX_LOG2_SIZE)) begin
            r = LOG2_BITS'(MAX_LOG2_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Signed frequency index, centered or in FFT order
    function automatic logic signed [FREQ_BITS-1:0] freq_index(
        input logic [POS_BITS-1:0]  pos,
        input logic [LOG2_BITS-1:0] lg,
        input logic                 centered
    );
        logic [FREQ_BITS-1:0] size;
        logic [FREQ_BITS-1:0] half;
        logic [FREQ_BITS-1:0] p;
        logic [FREQ_BITS-1:0] r;
        size = FREQ_BITS'(1) << lg;
        half = size >> 1;
        p    = {1'b0, pos} & (size - FREQ_BITS'(1));
        if (centered) begin
            r = p - half;
        end else if (p < half) begin
            r = p;
        end else begin
            r = p - size;
        end
        return $signed(r);
    endfunction

    logic [LOG2_BITS-1:0] lwc;
    logic [LOG2_BITS-1:0] lhc;

    // Stage 1 registers
    logic                          r_s1_valid;
    logic signed [FREQ_BITS-1:0]   r_s1_fx;
    logic signed [FREQ_BITS-1:0]   r_s1_fy;
    logic signed [SAMPLE_BITS-1:0] r_s1_re;
    logic signed [SAMPLE_BITS-1:0] r_s1_im;

    // Stage 2 registers
    logic                          r_s2_valid;
    logic [SUM_FRAC-1:0]           r_s2_tx;
    logic [SUM_FRAC-1:0]           r_s2_ty;
    logic signed [SAMPLE_BITS-1:0] r_s2_re;
    logic signed [SAMPLE_BITS-1:0] r_s2_im;

    // Stage 3 registers
    t_ang r_s3_ang;

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic [SUM_FRAC-1:0]      tx_s;
    logic [SUM_FRAC-1:0]      ty_s;
    logic [SUM_FRAC-1:0]      neg;
    logic [SUM_FRAC-1:0]      rnd;
    logic [PHASE_BITS-1:0]    p;
    logic [ANGLE_BITS-1:0]    a;
    logic [ANGLE_BITS-1:0]    a_red;
    logic                     flip;

    assign lwc = clamp_log2(i_cfg.log2_width);
    assign lhc = clamp_log2(i_cfg.log2_height);

    // Multiply shift by frequency, keep the fraction of a turn
    assign prod_x = i_cfg.shift_x * r_s1_fx;
    assign prod_y = i_cfg.shift_y * r_s1_fy;

    // Scale to a common grid, negate, round and reduce the angle
    always_comb begin
        tx_s  = r_s2_tx << (LOG2_BITS'(MAX_LOG2_SIZE) - lwc);
        ty_s  = r_s2_ty << (LOG2_BITS'(MAX_LOG2_SIZE) - lhc);
        neg   = SUM_FRAC'(0) - (tx_s + ty_s);
        rnd   = neg + (SUM_FRAC'(1) << (RND_SHIFT - 1));
        p     = rnd[SUM_FRAC-1 -: PHASE_BITS];
        a     = {p, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
        flip  = a[ANGLE_BITS-1] ^ a[ANGLE_BITS-2];
        a_red = flip ? (a ^ {1'b1, {(ANGLE_BITS - 1){1'b0}}}) : a;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_ang.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid     <= i_valid;
            r_s2_valid     <= r_s1_valid;
            r_s3_ang.valid <= r_s2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_fx <= freq_index(i_col, lwc, i_cfg.peak_centered);
            r_s1_fy <= freq_index(i_row, lhc, i_cfg.peak_centered);
            r_s1_re <= i_re;
            r_s1_im <= i_im;

            r_s2_tx <= prod_x[SUM_FRAC-1:0];
            r_s2_ty <= prod_y[SUM_FRAC-1:0];
            r_s2_re <= r_s1_re;
            r_s2_im <= r_s1_im;

            r_s3_ang.flip <= flip;
            r_s3_ang.z    <= $signed(a_red);
            r_s3_ang.re   <= r_s2_re;
            r_s3_ang.im   <= r_s2_im;
        end
    end

    assign o_ang = r_s3_ang;

endmodule

// File: rtl/core/fsr_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module fsr_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fsr_pkg::t_ang i_ang,
    output fsr_pkg::t_cor o_cor
);
    import fsr_pkg::*;

    t_cor r_st [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_cor src;
        t_cor n_st;

        // Start from the inverse gain on the x axis
        if (i == 0) begin : g_first
            always_comb begin
                src.valid = i_ang.valid;
                src.flip  = i_ang.flip;
                src.x     = INV_GAIN;
                src.y     = '0;
                src.z     = i_ang.z;
                src.re    = i_ang.re;
                src.im    = i_ang.im;
            end
        end else begin : g_next
            assign src = r_st[i-1];
        end

        // Rotate toward zero residual angle
        always_comb begin
            n_st = src;
            if (!src.z[ANGLE_BITS-1]) begin
                n_st.x = src.x - (src.y >>> i);
                n_st.y = src.y + (src.x >>> i);
                n_st.z = src.z - atan_turns(i);
            end else begin
                n_st.x = src.x + (src.y >>> i);
                n_st.y = src.y - (src.x >>> i);
                n_st.z = src.z + atan_turns(i);
            end
        end

        // Hold the stage while stalled
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[i].valid <= 1'b0;
            end else if (i_en) begin
                r_st[i].valid <= n_st.valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[i].flip <= n_st.flip;
                r_st[i].x    <= n_st.x;
                r_st[i].y    <= n_st.y;
                r_st[i].z    <= n_st.z;
                r_st[i].re   <= n_st.re;
                r_st[i].im   <= n_st.im;
            end
        end
    end

    assign o_cor = r_st[CORDIC_STEPS-1];

endmodule

// File: rtl/core/fsr_rotate.sv
// Complex multiply by cos + j*sin, then round and saturate.
module fsr_rotate (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fsr_pkg::t_cor i_cor,
    output fsr_pkg::t_res o_res
);
    import fsr_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Round half up by the fixed shift and clip to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] t;
        logic signed [RES_BITS-1:0] r;
        logic signed [SAMPLE_BITS-1:0] o;
        t = v + (SUM_BITS'(1) <<< (ROUND_SHIFT - 1));
        r = RES_BITS'(t >>> ROUND_SHIFT);
        if (r > RES_BITS'(SAT_HI)) begin
            o = SAT_HI;
        end else if (r < RES_BITS'(SAT_LO)) begin
            o = SAT_LO;
        end else begin
            o = r[SAMPLE_BITS-1:0];
        end
        return o;
    endfunction

    // Stage 1: partial products
    logic                        r_s1_valid;
    logic                        r_s1_flip;
    logic signed [PROD_BITS-1:0] r_s1_rx;
    logic signed [PROD_BITS-1:0] r_s1_iy;
    logic signed [PROD_BITS-1:0] r_s1_ry;
    logic signed [PROD_BITS-1:0] r_s1_ix;

    // Stage 2: sums, sign of the half turn folded in
    logic                       r_s2_valid;
    logic signed [SUM_BITS-1:0] r_s2_sr;
    logic signed [SUM_BITS-1:0] r_s2_si;

    // Stage 3: result
    t_res r_s3_res;

    logic signed [SUM_BITS-1:0] rx_e;
    logic signed [SUM_BITS-1:0] iy_e;
    logic signed [SUM_BITS-1:0] ry_e;
    logic signed [SUM_BITS-1:0] ix_e;

    assign rx_e = SUM_BITS'(r_s1_rx);
    assign iy_e = SUM_BITS'(r_s1_iy);
    assign ry_e = SUM_BITS'(r_s1_ry);
    assign ix_e = SUM_BITS'(r_s1_ix);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_res.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid     <= i_cor.valid;
            r_s2_valid     <= r_s1_valid;
            r_s3_res.valid <= r_s2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_flip <= i_cor.flip;
            r_s1_rx   <= i_cor.re * i_cor.x;
            r_s1_iy   <= i_cor.im * i_cor.y;
            r_s1_ry   <= i_cor.re * i_cor.y;
            r_s1_ix   <= i_cor.im * i_cor.x;

            if (r_s1_flip) begin
                r_s2_sr <= iy_e - rx_e;
                r_s2_si <= SUM_BITS'(0) - ry_e - ix_e;
            end else begin
                r_s2_sr <= rx_e - iy_e;
                r_s2_si <= ry_e + ix_e;
            end

            r_s3_res.re <= round_sat(r_s2_sr);
            r_s3_res.im <= round_sat(r_s2_si);
        end
    end

    assign o_res = r_s3_res;

endmodule

// File: rtl/core/fourier_shift_phase_ramp_top.sv
// Path from input transaction to output valid: 3 phase, 30 CORDIC, 3 multiply/round
// stages, 1 output register. Throughput: one transaction per cycle while the skid
// register is empty, set by the one-rotation-per-stage CORDIC pipeline.
// A skid register behind the output parks a result that arrives during an output stall.
// Reset (synchronous, active low) empties the pipeline and loads shifts 0,
// size exponents 6 and corner peak order; input is ready once reset is released.
module fourier_shift_phase_ramp_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fsr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [fsr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    fsr_in_if.sink                               i_in,
    fsr_out_if.source                            o_out
);
    import fsr_pkg::*;

    t_cfg r_cfg;
    logic en;
    t_ang ang;
    t_cor cor;
    t_res res;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_re;
    logic signed [SAMPLE_BITS-1:0] r_out_im;
    logic                          r_skid_valid;
    logic signed [SAMPLE_BITS-1:0] r_skid_re;
    logic signed [SAMPLE_BITS-1:0] r_skid_im;

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_x       <= '0;
            r_cfg.shift_y       <= '0;
            r_cfg.log2_width    <= LOG2_BITS'(6);
            r_cfg.log2_height   <= LOG2_BITS'(6);
            r_cfg.peak_centered <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHIFT_X:       r_cfg.shift_x       <= $signed(i_cfg_data[SHIFT_BITS-1:0]);
                CFG_SHIFT_Y:       r_cfg.shift_y       <= $signed(i_cfg_data[SHIFT_BITS-1:0]);
                CFG_LOG2_WIDTH:    r_cfg.log2_width    <= i_cfg_data[LOG2_BITS-1:0];
                CFG_LOG2_HEIGHT:   r_cfg.log2_height   <= i_cfg_data[LOG2_BITS-1:0];
                CFG_PEAK_CENTERED: r_cfg.peak_centered <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline advances while the skid register is free; hold off input in reset
    assign en         = !r_skid_valid;
    assign i_in.ready = en && i_rst_n;

    fsr_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .i_col   (i_in.col),
        .i_row   (i_in.row),
        .i_re    (i_in.in_re),
        .i_im    (i_in.in_im),
        .o_ang   (ang)
    );

    fsr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ang   (ang),
        .o_cor   (cor)
    );

    fsr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cor   (cor),
        .o_res   (res)
    );

    // Output register with skid: park a result that arrives during a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res.valid;
            end
        end else if (res.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_re <= r_skid_re;
                r_out_im <= r_skid_im;
            end else begin
                r_out_re <= res.re;
                r_out_im <= res.im;
            end
        end else if (res.valid && !r_skid_valid) begin
            r_skid_re <= res.re;
            r_skid_im <= res.im;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.out_re = r_out_re;
    assign o_out.out_im = r_out_im;

endmodule
